### rtl/fcfs_pkg.sv
// Shared types, constants and helper functions of the FCFS / round-robin scheduler.
package fcfs_pkg;

    localparam int NUM_PROCS = 5;
    localparam int ID_W      = 3;
    localparam int CNT_W     = 16;
    localparam int LEN_W     = 3;
    localparam int SLICE_W   = 8;
    localparam int FUNC_W    = 2;

    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 48;

    localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    // Step kinds carried on s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK_ARR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ARRIVE   = 2'd2;

    // Register index selected by paddr[2].
    localparam logic REG_MODE    = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_RR   = 1'b1;

    // Bit positions of the result fields on m_tdata.
    localparam int M_RAN_LO    = 0;
    localparam int M_FIN_BIT   = 3;
    localparam int M_FPROC_LO  = 4;
    localparam int M_RESP_LO   = 7;
    localparam int M_WAIT_LO   = 23;
    localparam int M_SWITCH_BIT = 39;
    localparam int M_EMPTY_BIT = 40;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic       ready_empty;
        logic       switch_after;
        cnt_t       finished_wait;
        cnt_t       finished_resp;
        id_t        finished_proc;
        logic       finished;
        id_t        ran_proc;
    } result_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

endpackage

### rtl/fcfs_rr_cpu_scheduler_top.sv
// Top level of the tick-driven FCFS / round-robin CPU scheduler.
// A tick transfer's result is registered and shows on m_tdata after the edge that accepts it.
// Throughput: one input transfer per cycle while s_tready is high; arrival-only steps produce no result.
// s_tready stays high while the result register is empty or being drained.
// Reset (aresetn low, synchronous) empties the ready queue, clears the running
// process, slice and per-process counters, and sets round-robin mode off, quantum 1.
module fcfs_rr_cpu_scheduler_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] arrival_proc, [18:3] arrival_burst, [23:19] zero.
    input  logic [fcfs_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] func.
    input  logic [fcfs_pkg::FUNC_W-1:0]      s_tuser,
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] ran_proc, [3] finished, [6:4] finished_proc, [22:7] finished_resp,
    // [38:23] finished_wait, [39] switch_after, [40] ready_empty, [47:41] zero.
    output logic [fcfs_pkg::M_DATA_W-1:0]    m_tdata,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int N = fcfs_pkg::NUM_PROCS;

    // Configuration registers.
    logic                              mode_reg;
    logic [fcfs_pkg::SLICE_W-1:0]      quantum_reg;

    // Scheduler state.
    fcfs_pkg::id_t                     fifo_reg  [N];
    fcfs_pkg::id_t                     fifo_next [N];
    logic [fcfs_pkg::LEN_W-1:0]        count_reg, count_next;
    fcfs_pkg::id_t                     running_reg, running_next;
    logic [fcfs_pkg::SLICE_W-1:0]      slice_reg, slice_next;
    fcfs_pkg::cnt_t                    burst_reg [N];
    fcfs_pkg::cnt_t                    burst_next [N];
    fcfs_pkg::cnt_t                    run_reg  [N];
    fcfs_pkg::cnt_t                    run_next [N];
    fcfs_pkg::cnt_t                    resp_reg  [N];
    fcfs_pkg::cnt_t                    resp_next [N];
    fcfs_pkg::cnt_t                    wait_reg  [N];
    fcfs_pkg::cnt_t                    wait_next [N];

    // Result register.
    logic                              m_valid_reg;
    fcfs_pkg::result_t                 res_reg, res_next;

    // Step decode and intermediate values.
    logic                              s_accept;
    logic                              is_tick, do_arrive;
    fcfs_pkg::id_t                     a_proc, ran;
    fcfs_pkg::cnt_t                    a_burst;
    logic [N-1:0]                      queued;
    logic                              dup;
    fcfs_pkg::cnt_t                    ran_run, ran_burst, ran_resp, ran_wait;
    logic [fcfs_pkg::SLICE_W-1:0]      q_eff;
    logic                              fin, released;
    logic                              cfg_write;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(fcfs_pkg::M_DATA_W - $bits(fcfs_pkg::result_t)){1'b0}}, res_reg};

    assign a_proc    = s_tdata[2:0];
    assign a_burst   = s_tdata[18:3];
    assign is_tick   = (s_tuser == fcfs_pkg::FUNC_TICK) || (s_tuser == fcfs_pkg::FUNC_TICK_ARR);
    assign do_arrive = (s_tuser == fcfs_pkg::FUNC_TICK_ARR) || (s_tuser == fcfs_pkg::FUNC_ARRIVE);
    assign q_eff     = (quantum_reg == '0) ? fcfs_pkg::SLICE_W'(1) : quantum_reg;

    // APB: always ready, paddr[2] selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == fcfs_pkg::REG_QUANTUM)
                     ? {24'd0, quantum_reg} : {31'd0, mode_reg};

    // One scheduler step. The order follows the tick semantics: dispatch, accounting,
    // arrival, then completion or preemption, with a preempted process queued last.
    always_comb begin
        fifo_next    = fifo_reg;
        count_next   = count_reg;
        running_next = running_reg;
        slice_next   = slice_reg;
        burst_next   = burst_reg;
        run_next     = run_reg;
        resp_next    = resp_reg;
        wait_next    = wait_reg;
        res_next     = res_reg;
        ran          = '0;
        queued       = '0;
        dup          = 1'b0;
        ran_run      = '0;
        ran_burst    = '0;
        ran_resp     = '0;
        ran_wait     = '0;
        fin          = 1'b0;
        released     = 1'b0;

        if (s_accept && is_tick) begin
            // Dispatch the head of the queue onto an idle CPU.
            if (running_reg == '0 && count_reg != '0) begin
                running_next = fifo_reg[0];
                for (int i = 0; i < N - 1; i++) begin
                    fifo_next[i] = fifo_reg[i+1];
                end
                fifo_next[N-1] = '0;
                count_next     = count_reg - fcfs_pkg::LEN_W'(1);
                slice_next     = '0;
            end
            ran = running_next;

            if (ran != '0) begin
                for (int p = 0; p < N; p++) begin
                    if (ran == fcfs_pkg::ID_W'(p + 1)) begin
                        run_next[p] = fcfs_pkg::sat_inc(run_reg[p]);
                    end
                end
                for (int i = 0; i < N; i++) begin
                    for (int p = 0; p < N; p++) begin
                        if ((fcfs_pkg::LEN_W'(i) < count_next) &&
                            (fifo_next[i] == fcfs_pkg::ID_W'(p + 1))) begin
                            queued[p] = 1'b1;
                        end
                    end
                end
                for (int p = 0; p < N; p++) begin
                    if (queued[p]) begin
                        if (run_reg[p] == '0) begin
                            resp_next[p] = fcfs_pkg::sat_inc(resp_reg[p]);
                        end
                        wait_next[p] = fcfs_pkg::sat_inc(wait_reg[p]);
                    end
                end
                if (slice_reg != fcfs_pkg::SLICE_MAX || slice_next == '0) begin
                    slice_next = slice_next + fcfs_pkg::SLICE_W'(1);
                end
            end
        end

        // Arrival: ignored for a bad id or a process already queued or running.
        if (s_accept && do_arrive) begin
            for (int i = 0; i < N; i++) begin
                if ((fcfs_pkg::LEN_W'(i) < count_next) && (fifo_next[i] == a_proc)) begin
                    dup = 1'b1;
                end
            end
            if (a_proc != '0 && a_proc <= fcfs_pkg::ID_W'(N) && a_proc != running_next
                && !dup) begin
                for (int p = 0; p < N; p++) begin
                    if (a_proc == fcfs_pkg::ID_W'(p + 1)) begin
                        burst_next[p] = (a_burst == '0) ? fcfs_pkg::CNT_W'(1) : a_burst;
                        run_next[p]   = '0;
                        resp_next[p]  = '0;
                        wait_next[p]  = '0;
                    end
                end
                for (int i = 0; i < N; i++) begin
                    if (fcfs_pkg::LEN_W'(i) == count_next) begin
                        fifo_next[i] = a_proc;
                    end
                end
                if (count_next < fcfs_pkg::LEN_W'(N)) begin
                    count_next = count_next + fcfs_pkg::LEN_W'(1);
                end
            end
        end

        if (s_accept && is_tick) begin
            for (int p = 0; p < N; p++) begin
                if (ran == fcfs_pkg::ID_W'(p + 1)) begin
                    ran_run   = run_next[p];
                    ran_burst = burst_reg[p];
                    ran_resp  = resp_reg[p];
                    ran_wait  = wait_reg[p];
                end
            end
            if (ran != '0) begin
                if (ran_run >= ran_burst) begin
                    fin          = 1'b1;
                    released     = 1'b1;
                    running_next = '0;
                    slice_next   = '0;
                end else if (mode_reg == fcfs_pkg::MODE_RR && slice_next >= q_eff) begin
                    released     = 1'b1;
                    running_next = '0;
                    slice_next   = '0;
                end
            end

            res_next.ran_proc      = ran;
            res_next.finished      = fin;
            res_next.finished_proc = fin ? ran : '0;
            res_next.finished_resp = fin ? ran_resp : '0;
            res_next.finished_wait = fin ? ran_wait : '0;
            res_next.switch_after  = released && (count_next != '0);

            // A preempted process rejoins behind any arrival of this tick.
            if (released && !fin) begin
                for (int i = 0; i < N; i++) begin
                    if (fcfs_pkg::LEN_W'(i) == count_next) begin
                        fifo_next[i] = ran;
                    end
                end
                if (count_next < fcfs_pkg::LEN_W'(N)) begin
                    count_next = count_next + fcfs_pkg::LEN_W'(1);
                end
            end
            res_next.ready_empty = (count_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= fcfs_pkg::MODE_FCFS;
            quantum_reg <= fcfs_pkg::SLICE_W'(1);
            count_reg   <= '0;
            running_reg <= '0;
            slice_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int p = 0; p < N; p++) begin
                fifo_reg[p] <= '0;
                run_reg[p]  <= '0;
                resp_reg[p] <= '0;
                wait_reg[p] <= '0;
            end
        end else begin
            if (cfg_write) begin
                if (paddr[2] == fcfs_pkg::REG_QUANTUM) begin
                    quantum_reg <= pwdata[7:0];
                end else begin
                    mode_reg <= pwdata[0];
                end
            end
            fifo_reg    <= fifo_next;
            count_reg   <= count_next;
            running_reg <= running_next;
            slice_reg   <= slice_next;
            run_reg     <= run_next;
            resp_reg    <= resp_next;
            wait_reg    <= wait_next;
            if (s_accept && is_tick) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Burst lengths are only read for processes that have arrived, so they need no reset.
    always_ff @(posedge aclk) begin
        burst_reg <= burst_next;
        res_reg   <= res_next;
    end

endmodule

### rtl/fcfs_chk.sv
// Port-level assertion checker for the scheduler, bound to the top level.
module fcfs_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fcfs_pkg::M_DATA_W-1:0] m_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // With the result register empty the input side must be open.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result register");

    // An idle tick cannot complete a process or cause a switch.
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[fcfs_pkg::M_RAN_LO +: 3] == 3'd0 |->
            !m_tdata[fcfs_pkg::M_FIN_BIT] && !m_tdata[fcfs_pkg::M_SWITCH_BIT])
        else $error("idle tick reports activity");

    // The completed process is the one that ran; no completion carries zero fields.
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[fcfs_pkg::M_FIN_BIT]
            ? (m_tdata[fcfs_pkg::M_FPROC_LO +: 3] == m_tdata[fcfs_pkg::M_RAN_LO +: 3])
            : (m_tdata[fcfs_pkg::M_FPROC_LO +: 3] == 3'd0 &&
               m_tdata[fcfs_pkg::M_RESP_LO +: 16] == 16'd0 &&
               m_tdata[fcfs_pkg::M_WAIT_LO +: 16] == 16'd0)))
        else $error("inconsistent completion fields");

    // A context switch needs a waiting process, so the queue cannot be empty.
    a_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[fcfs_pkg::M_SWITCH_BIT] |-> !m_tdata[fcfs_pkg::M_EMPTY_BIT])
        else $error("switch reported with empty queue");

endmodule

bind fcfs_rr_cpu_scheduler_top fcfs_chk u_fcfs_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/fcfs_sched_check_pkg.sv
// Scoreboard class that predicts and checks the results of the FCFS / round-robin scheduler.
package fcfs_sched_check_pkg;
    import fcfs_pkg::*;

    class sched_checker;
        logic               rr_mode;
        logic [SLICE_W-1:0] slice_limit;
        id_t                ready_q[$];
        id_t                running;
        logic [SLICE_W-1:0] slice_used;
        cnt_t               burst_len [NUM_PROCS+1];
        cnt_t               run_cnt   [NUM_PROCS+1];
        cnt_t               resp_cnt  [NUM_PROCS+1];
        cnt_t               wait_cnt  [NUM_PROCS+1];
        result_t            expected_results[$];
        int                 errors;

        function new();
            rr_mode     = MODE_FCFS;
            slice_limit = SLICE_W'(1);
            running     = '0;
            slice_used  = '0;
            errors      = 0;
            foreach (burst_len[i]) begin
                burst_len[i] = '0;
                run_cnt[i]   = '0;
                resp_cnt[i]  = '0;
                wait_cnt[i]  = '0;
            end
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_MODE) begin
                rr_mode = value[0];
            end else begin
                slice_limit = value[SLICE_W-1:0];
            end
        endfunction

        function bit is_idle();
            return running == '0 && ready_q.size() == 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        local function cnt_t bump(cnt_t v);
            return (v == '1) ? v : v + cnt_t'(1);
        endfunction

        // A new process is taken only if its id is valid and it is neither
        // running nor already waiting.
        local function void admit(id_t id, cnt_t burst);
            if (id == 0 || id > NUM_PROCS || id == running) return;
            foreach (ready_q[i]) begin
                if (ready_q[i] == id) return;
            end
            burst_len[id] = (burst == 0) ? cnt_t'(1) : burst;
            run_cnt[id]   = '0;
            resp_cnt[id]  = '0;
            wait_cnt[id]  = '0;
            if (ready_q.size() < NUM_PROCS) ready_q.push_back(id);
        endfunction

        function void note_transfer(logic [FUNC_W-1:0] func, id_t id, cnt_t burst);
            id_t                cur;
            logic [SLICE_W-1:0] lim;
            bit                 done;
            bit                 freed;
            result_t            r;
            if (func == FUNC_ARRIVE) begin
                admit(id, burst);
                return;
            end
            if (func != FUNC_TICK && func != FUNC_TICK_ARR) return;

            if (running == '0 && ready_q.size() > 0) begin
                running    = ready_q.pop_front();
                slice_used = '0;
            end
            cur   = running;
            done  = 0;
            freed = 0;
            if (cur != '0) begin
                run_cnt[cur] = bump(run_cnt[cur]);
                foreach (ready_q[i]) begin
                    if (run_cnt[ready_q[i]] == '0)
                        resp_cnt[ready_q[i]] = bump(resp_cnt[ready_q[i]]);
                    wait_cnt[ready_q[i]] = bump(wait_cnt[ready_q[i]]);
                end
                if (slice_used != SLICE_MAX) slice_used++;
            end

            if (func == FUNC_TICK_ARR) admit(id, burst);

            r = '0;
            r.ran_proc = cur;
            if (cur != '0) begin
                lim = (slice_limit == '0) ? SLICE_W'(1) : slice_limit;
                if (run_cnt[cur] >= burst_len[cur]) begin
                    done            = 1;
                    r.finished      = 1'b1;
                    r.finished_proc = cur;
                    r.finished_resp = resp_cnt[cur];
                    r.finished_wait = wait_cnt[cur];
                end else if (rr_mode == MODE_RR && slice_used >= lim) begin
                    freed = 1;
                end
                if (done || freed) begin
                    running    = '0;
                    slice_used = '0;
                end
            end
            r.switch_after = (done || freed) && ready_q.size() > 0;
            if (freed && ready_q.size() < NUM_PROCS) ready_q.push_back(cur);
            r.ready_empty = (ready_q.size() == 0);
            expected_results.push_back(r);
        endfunction

        local function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            result_t want;
            result_t got;
            if (expected_results.size() == 0) begin
                $error("result transfer %h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            got  = result_t'(data[$bits(result_t)-1:0]);
            compare("ran_proc",      32'(want.ran_proc),      32'(got.ran_proc));
            compare("finished",      32'(want.finished),      32'(got.finished));
            compare("finished_proc", 32'(want.finished_proc), 32'(got.finished_proc));
            compare("finished_resp", 32'(want.finished_resp), 32'(got.finished_resp));
            compare("finished_wait", 32'(want.finished_wait), 32'(got.finished_wait));
            compare("switch_after",  32'(want.switch_after),  32'(got.switch_after));
            compare("ready_empty",   32'(want.ready_empty),   32'(got.ready_empty));
        endfunction
    endclass

endpackage

### tb/fcfs_rr_cpu_scheduler_top_tb.sv
// Testbench of the scheduler top level: directed and random steps checked against a predictor.
module fcfs_rr_cpu_scheduler_top_tb;
    import fcfs_pkg::*;
    import fcfs_sched_check_pkg::*;

    // Step kind that the block has to ignore.
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_MODE    = 3'd0;
    localparam logic [2:0] ADDR_QUANTUM = 3'd4;

    // The result of a tick is registered; the settle time covers any work in flight.
    localparam int SETTLE_CYCLES = 4;
    // Long receiver hold-off, long enough to back the block up into its input.
    localparam int HOLD_CYCLES   = 80;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 150;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [2:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    sched_checker sb;

    // When calm is set neither side inserts gaps; hold_request asks the
    // receiver for one long hold-off and is cleared by the receiver.
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    fcfs_rr_cpu_scheduler_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Short bursts keep processes cycling through the queue; a zero burst
    // shows up now and then, and a few longer ones stretch the slices.
    function automatic cnt_t pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 88) return cnt_t'($urandom_range(1, 12));
        return cnt_t'($urandom_range(13, 300));
    endfunction

    // Offers one step and returns at the edge where the transfer happens.
    // Valid stays high on return so that the next step can follow without a gap.
    task automatic send(logic [FUNC_W-1:0] func, id_t id, cnt_t burst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'b0, burst, id};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_transfer(func, id, burst);
    endtask

    // Stops offering steps and waits until every expected result has been
    // taken, plus a settle time for an arrival-only step still in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup phase, access phase, then an idle phase so that back-to-back
    // writes never drive psel twice in the same step.
    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers change only once no step is in flight; a process may still hold the CPU.
    task automatic set_config(logic mode, logic [SLICE_W-1:0] slice_len);
        settle();
        apb_write(ADDR_MODE, {31'b0, mode});
        sb.write_reg(REG_MODE, {31'b0, mode});
        apb_write(ADDR_QUANTUM, {24'b0, slice_len});
        sb.write_reg(REG_QUANTUM, {24'b0, slice_len});
    endtask

    // Plain ticks until nothing runs and nothing waits; the arrival fields of
    // a tick are don't-care, so they carry random bits.
    task automatic run_until_idle();
        while (!sb.is_idle()) send(FUNC_TICK, id_t'($urandom), cnt_t'($urandom));
    endtask

    // Most steps are ticks and valid arrivals; the rest draws random step
    // kinds, unknown ones included, and process ids that may be out of range.
    task automatic random_item();
        int              r;
        logic [FUNC_W-1:0] func;
        id_t             id;
        cnt_t            burst;
        r     = $urandom_range(0, 99);
        id    = id_t'($urandom_range(1, NUM_PROCS));
        burst = pick_burst();
        if (r < 50) begin
            func = FUNC_TICK;
        end else if (r < 70) begin
            func = FUNC_TICK_ARR;
        end else if (r < 88) begin
            func = FUNC_ARRIVE;
        end else begin
            func = FUNC_W'($urandom_range(0, 3));
            id   = id_t'($urandom_range(0, 7));
        end
        send(func, id, burst);
    endtask

    // Receiver: random back-pressure, one long hold-off on request, and a
    // check of every result transfer against the oldest expectation.
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic               mode_sel;
        logic [SLICE_W-1:0] slice_sel;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part in the reset configuration (first-come-first-served).
        // A tick with nothing ready is an idle tick; an unknown step kind
        // does nothing at all.
        send(FUNC_TICK, '0, '0);
        send(FUNC_NONE, id_t'(5), cnt_t'(3));
        // Bad ids are ignored, including one with an all-ones burst.
        send(FUNC_ARRIVE, id_t'(0), cnt_t'(7));
        send(FUNC_ARRIVE, id_t'(6), cnt_t'(7));
        send(FUNC_ARRIVE, id_t'(7), 16'hFFFF);
        // A zero burst counts as one tick, so process 1 completes on its first tick
        // while process 2 arrives at the end of that same tick.
        send(FUNC_ARRIVE, id_t'(1), '0);
        send(FUNC_TICK_ARR, id_t'(2), cnt_t'(2));
        // Duplicate arrivals: first while queued, then while running.
        send(FUNC_ARRIVE, id_t'(2), cnt_t'(9));
        send(FUNC_TICK, '0, '0);
        send(FUNC_ARRIVE, id_t'(2), cnt_t'(4));
        send(FUNC_ARRIVE, id_t'(3), cnt_t'(3));
        send(FUNC_ARRIVE, id_t'(4), cnt_t'(1));
        send(FUNC_ARRIVE, id_t'(5), cnt_t'(2));
        send(FUNC_TICK, id_t'(7), 16'hFFFF);
        // Round robin with a zero quantum, which acts as a quantum of one.
        set_config(MODE_RR, 8'd0);
        repeat (3) send(FUNC_TICK, '0, '0);
        send(FUNC_TICK_ARR, id_t'(1), cnt_t'(3));
        // Quantum changed while a process holds the CPU: its slice count is kept.
        set_config(MODE_RR, 8'd255);
        repeat (3) send(FUNC_TICK, '0, '0);
        set_config(MODE_FCFS, 8'd1);
        run_until_idle();

        // Random phases, each under its own configuration. Within every phase
        // one stretch runs without gaps, and the sender sometimes pauses
        // until all results are in.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin mode_sel = MODE_RR;   slice_sel = 8'd1; end
                1: begin mode_sel = MODE_RR;   slice_sel = SLICE_W'($urandom_range(2, 6)); end
                2: begin mode_sel = MODE_FCFS; slice_sel = SLICE_W'($urandom); end
                3: begin mode_sel = MODE_RR;   slice_sel = 8'd255; end
                4: begin mode_sel = MODE_RR;   slice_sel = 8'd0; end
                default: begin mode_sel = MODE_RR; slice_sel = SLICE_W'($urandom_range(1, 255)); end
            endcase
            set_config(mode_sel, slice_sel);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                calm = (n >= 100 && n < 130);
                // The receiver stalls for a long while as the sender keeps
                // offering steps, so the block has to hold back its input.
                if (p == 1 && n == 40) hold_request = 1'b1;
                if ($urandom_range(0, 49) == 0) settle();
                random_item();
            end
        end
        calm = 1'b0;
        run_until_idle();

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/fcfs_pkg.sv
rtl/fcfs_rr_cpu_scheduler_top.sv
rtl/fcfs_chk.sv
tb/fcfs_sched_check_pkg.sv
tb/fcfs_rr_cpu_scheduler_top_tb.sv
